FILE: sv/lpi_pkg.sv
// Shared widths, configuration register codes and item types for the
// line/plane intersection unit. No dependencies.
package lpi_pkg;

  localparam int CW = 32;            // coordinate width
  localparam int FB = 16;            // fraction bits
  localparam int DW = CW + 1;        // coordinate difference
  localparam int PW = CW + DW;       // normal times difference
  localparam int SW = PW + 2;        // dot product sum
  localparam int XW = SW + FB;       // scaled numerator magnitude
  localparam int HW = PW - FB + 1;   // unsaturated hit coordinate
  localparam int CFG_IW = 3;
  localparam int QDEPTH = 2;
  localparam int QAW = 1;

  typedef enum logic [CFG_IW-1:0] {
    CFG_PX = 3'd0,
    CFG_PY = 3'd1,
    CFG_PZ = 3'd2,
    CFG_NX = 3'd3,
    CFG_NY = 3'd4,
    CFG_NZ = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [2:0][CW-1:0] p;
    logic [2:0][CW-1:0] n;
  } lpi_plane_t;

  typedef struct packed {
    logic [2:0][CW-1:0] a;   // segment start
    logic [2:0][DW-1:0] d;   // end minus start
    logic               par; // denominator is zero
    logic               neg; // quotient sign
  } lpi_side_t;

  typedef struct packed {
    lpi_side_t     side;
    logic [SW-1:0] nabs;
    logic [SW-1:0] dabs;
  } lpi_job_t;

endpackage

FILE: sv/lpi_front.sv
// Front end: differences, dot products and classification of each item.
// Depends on lpi_pkg.
module lpi_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_take,
  input  logic [2:0][lpi_pkg::CW-1:0] a_in,
  input  logic [2:0][lpi_pkg::CW-1:0] b_in,
  input  lpi_pkg::lpi_plane_t         plane,
  output logic                        job_valid,
  output lpi_pkg::lpi_job_t           job
);
  import lpi_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r;
  logic [2:0][CW-1:0] a1_r, a2_r, a3_r;
  logic signed [DW-1:0] d1_r [3];
  logic signed [DW-1:0] e1_r [3];
  logic signed [DW-1:0] d2_r [3];
  logic signed [DW-1:0] d3_r [3];
  logic signed [PW-1:0] pn2_r [3];
  logic signed [PW-1:0] pd2_r [3];
  logic signed [SW-1:0] num3_r, den3_r;
  logic signed [SW-1:0] num_nxt, den_nxt;
  lpi_job_t job_r, job_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_take;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    a1_r <= a_in;
    a2_r <= a1_r;
    a3_r <= a2_r;
    for (int i = 0; i < 3; i++) begin
      d1_r[i]  <= DW'($signed(b_in[i])) - DW'($signed(a_in[i]));
      e1_r[i]  <= DW'($signed(plane.p[i])) - DW'($signed(a_in[i]));
      d2_r[i]  <= d1_r[i];
      d3_r[i]  <= d2_r[i];
      pn2_r[i] <= PW'($signed(plane.n[i]) * e1_r[i]);
      pd2_r[i] <= PW'($signed(plane.n[i]) * d1_r[i]);
    end
    num3_r <= num_nxt;
    den3_r <= den_nxt;
    job_r  <= job_nxt;
  end

  always_comb begin
    num_nxt = SW'(pn2_r[0]) + SW'(pn2_r[1]) + SW'(pn2_r[2]);
    den_nxt = SW'(pd2_r[0]) + SW'(pd2_r[1]) + SW'(pd2_r[2]);
  end

  always_comb begin
    job_nxt.side.a = a3_r;
    for (int i = 0; i < 3; i++) begin
      job_nxt.side.d[i] = d3_r[i];
    end
    job_nxt.side.par = (den3_r == '0);
    job_nxt.side.neg = num3_r[SW-1] ^ den3_r[SW-1];
    job_nxt.nabs = num3_r[SW-1] ? SW'(-num3_r) : num3_r;
    job_nxt.dabs = den3_r[SW-1] ? SW'(-den3_r) : den3_r;
  end

  assign job_valid = v4_r;
  assign job       = job_r;

endmodule

FILE: sv/lpi_queue.sv
// Short queue between front and back ends. Depends on lpi_pkg.
module lpi_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lpi_pkg::lpi_job_t wdata,
  output logic              rd_valid,
  output lpi_pkg::lpi_job_t rdata
);
  import lpi_pkg::*;

  lpi_job_t mem [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0] cnt_r, cnt_nxt;
  logic pop;
  logic rd_valid_r;
  lpi_job_t rdata_r;

  // back end never stalls: drain one item per cycle
  assign pop = (cnt_r != '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      rp_r       <= '0;
      cnt_r      <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r      <= cnt_nxt;
      rd_valid_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= wdata;
    if (pop) rdata_r <= mem[rp_r];
  end

  assign rd_valid = rd_valid_r;
  assign rdata    = rdata_r;

endmodule

FILE: sv/lpi_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with a
// quotient-overflow check ahead of it. Depends on lpi_pkg.
module lpi_divider (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   job_valid,
  input  lpi_pkg::lpi_job_t      job,
  output logic                   q_valid,
  output lpi_pkg::lpi_side_t     q_side,
  output logic [lpi_pkg::CW-1:0] q_mag,
  output logic                   q_hiovf
);
  import lpi_pkg::*;

  logic            v_r    [CW+1];
  logic [SW-1:0]   rem_r  [CW+1];
  logic [CW-1:0]   q_r    [CW+1];
  logic [CW-1:0]   low_r  [CW+1];
  logic [SW-1:0]   y_r    [CW+1];
  lpi_side_t       side_r [CW+1];
  logic            hov_r  [CW+1];

  logic [XW-1:0]    x;
  logic [SW+CW-1:0] xe, ye;
  logic [SW:0]      r2    [CW];
  logic [SW-1:0]    rem_nxt [CW];
  logic             qb    [CW];

  always_comb begin
    x  = {job.nabs, {FB{1'b0}}};
    xe = (SW+CW)'(x);
    ye = {job.dabs, {CW{1'b0}}};
    for (int k = 0; k < CW; k++) begin
      r2[k] = {rem_r[k], low_r[k][CW-1]};
      qb[k] = (r2[k] >= {1'b0, y_r[k]});
      rem_nxt[k] = qb[k] ? SW'(r2[k] - {1'b0, y_r[k]}) : SW'(r2[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= CW; k++) v_r[k] <= 1'b0;
    end else begin
      v_r[0] <= job_valid;
      for (int k = 0; k < CW; k++) v_r[k+1] <= v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    // quotient fits CW bits only when x < y * 2^CW
    hov_r[0]  <= (xe >= ye);
    rem_r[0]  <= SW'(x >> CW);
    low_r[0]  <= x[CW-1:0];
    q_r[0]    <= '0;
    y_r[0]    <= job.dabs;
    side_r[0] <= job.side;
    for (int k = 0; k < CW; k++) begin
      rem_r[k+1]  <= rem_nxt[k];
      low_r[k+1]  <= {low_r[k][CW-2:0], 1'b0};
      q_r[k+1]    <= {q_r[k][CW-2:0], qb[k]};
      y_r[k+1]    <= y_r[k];
      side_r[k+1] <= side_r[k];
      hov_r[k+1]  <= hov_r[k];
    end
  end

  assign q_valid = v_r[CW];
  assign q_side  = side_r[CW];
  assign q_mag   = q_r[CW];
  assign q_hiovf = hov_r[CW];

endmodule

FILE: sv/lpi_back.sv
// Back end: division for t, scaling of the segment direction, add and
// saturate. Depends on lpi_pkg and lpi_divider.
module lpi_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   job_valid,
  input  lpi_pkg::lpi_job_t      job,
  output logic                   res_valid,
  output logic [lpi_pkg::CW-1:0] hit_x,
  output logic [lpi_pkg::CW-1:0] hit_y,
  output logic [lpi_pkg::CW-1:0] hit_z,
  output logic                   par_flag,
  output logic                   ovf_flag
);
  import lpi_pkg::*;

  localparam logic [CW-1:0] SMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] SMIN = {1'b1, {(CW-1){1'b0}}};

  logic             dv;
  lpi_side_t        dside;
  logic [CW-1:0]    dq;
  logic             dhov;

  logic             tv_r, mv_r, ov_r;
  lpi_side_t        tside_r, mside_r;
  logic signed [CW-1:0] t_r, t_nxt;
  logic             tovf_r, tovf_nxt, movf_r;
  logic signed [PW-1:0] prod_r [3];
  logic [2:0][CW-1:0] out_r, out_nxt;
  logic             opar_r, oovf_r, oovf_nxt;
  logic signed [PW-1:0] sh;
  logic signed [HW-1:0] h;

  lpi_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .q_valid   (dv),
    .q_side    (dside),
    .q_mag     (dq),
    .q_hiovf   (dhov)
  );

  always_comb begin
    if (dside.neg) begin
      tovf_nxt = dhov || (dq > SMIN);
      t_nxt    = tovf_nxt ? SMIN : CW'(-dq);
    end else begin
      tovf_nxt = dhov || dq[CW-1];
      t_nxt    = tovf_nxt ? SMAX : dq;
    end
  end

  always_comb begin
    oovf_nxt = movf_r;
    sh = '0;
    h  = '0;
    for (int i = 0; i < 3; i++) begin
      sh = prod_r[i] >>> FB;
      h  = HW'($signed(mside_r.a[i])) + HW'(sh);
      if (h[HW-1:CW-1] != {(HW-CW+1){h[HW-1]}}) begin
        oovf_nxt   = 1'b1;
        out_nxt[i] = h[HW-1] ? SMIN : SMAX;
      end else begin
        out_nxt[i] = h[CW-1:0];
      end
    end
    if (mside_r.par) begin
      out_nxt  = mside_r.a;
      oovf_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r <= 1'b0;
      mv_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      tv_r <= dv;
      mv_r <= tv_r;
      ov_r <= mv_r;
    end
  end

  always_ff @(posedge clk) begin
    tside_r <= dside;
    t_r     <= t_nxt;
    tovf_r  <= tovf_nxt;
    mside_r <= tside_r;
    movf_r  <= tovf_r;
    for (int i = 0; i < 3; i++) begin
      prod_r[i] <= PW'($signed(tside_r.d[i]) * t_r);
    end
    out_r  <= out_nxt;
    opar_r <= mside_r.par;
    oovf_r <= oovf_nxt;
  end

  assign res_valid = ov_r;
  assign hit_x     = out_r[0];
  assign hit_y     = out_r[1];
  assign hit_z     = out_r[2];
  assign par_flag  = opar_r;
  assign ovf_flag  = oovf_r;

endmodule

FILE: sv/line_plane_intersection_unit.sv
// Line/plane intersection unit: one segment in, one intersection point out
// per item, Q16.16. Depends on lpi_pkg, lpi_front, lpi_queue, lpi_back.
//
// Takes a new segment every clock cycle; busy is always low. Each result
// appears on the out_ ports for one cycle, marked by out_valid; most of the
// delay comes from the 32-stage quotient pipeline that forms t. The receiver
// cannot stall, so results must be captured when out_valid is high. The user
// must write the plane registers through the cfg_ port only while no item is
// in flight; the block itself does not enforce this. Indexes above 5 are ignored.
module line_plane_intersection_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [lpi_pkg::CW-1:0]       in_start_x,
  input  logic signed [lpi_pkg::CW-1:0]       in_start_y,
  input  logic signed [lpi_pkg::CW-1:0]       in_start_z,
  input  logic signed [lpi_pkg::CW-1:0]       in_end_x,
  input  logic signed [lpi_pkg::CW-1:0]       in_end_y,
  input  logic signed [lpi_pkg::CW-1:0]       in_end_z,
  output logic                                out_valid,
  output logic signed [lpi_pkg::CW-1:0]       out_hit_x,
  output logic signed [lpi_pkg::CW-1:0]       out_hit_y,
  output logic signed [lpi_pkg::CW-1:0]       out_hit_z,
  output logic                                out_parallel_flag,
  output logic                                out_overflow_flag,
  input  logic                                cfg_we,
  input  logic [lpi_pkg::CFG_IW-1:0]          cfg_index,
  input  logic [lpi_pkg::CW-1:0]              cfg_wdata
);
  import lpi_pkg::*;

  localparam logic [CW-1:0] ONE = CW'(1) << FB;

  lpi_plane_t plane_r;
  logic in_take;
  logic [2:0][CW-1:0] a_in, b_in;
  logic fj_valid, qj_valid;
  lpi_job_t fj, qj;
  logic [CW-1:0] hx, hy, hz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r.p <= '0;
      plane_r.n <= {ONE, {CW{1'b0}}, {CW{1'b0}}};
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PX:  plane_r.p[0] <= cfg_wdata;
        CFG_PY:  plane_r.p[1] <= cfg_wdata;
        CFG_PZ:  plane_r.p[2] <= cfg_wdata;
        CFG_NX:  plane_r.n[0] <= cfg_wdata;
        CFG_NY:  plane_r.n[1] <= cfg_wdata;
        CFG_NZ:  plane_r.n[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy    = 1'b0;
  assign in_take = start && !busy;
  assign a_in    = {in_start_z, in_start_y, in_start_x};
  assign b_in    = {in_end_z, in_end_y, in_end_x};

  lpi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_take   (in_take),
    .a_in      (a_in),
    .b_in      (b_in),
    .plane     (plane_r),
    .job_valid (fj_valid),
    .job       (fj)
  );

  lpi_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fj_valid),
    .wdata    (fj),
    .rd_valid (qj_valid),
    .rdata    (qj)
  );

  lpi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (qj_valid),
    .job       (qj),
    .res_valid (out_valid),
    .hit_x     (hx),
    .hit_y     (hy),
    .hit_z     (hz),
    .par_flag  (out_parallel_flag),
    .ovf_flag  (out_overflow_flag)
  );

  assign out_hit_x = $signed(hx);
  assign out_hit_y = $signed(hy);
  assign out_hit_z = $signed(hz);

endmodule

FILE: tb/line_plane_intersection_unit_tb.sv
// Testbench for the line/plane intersection unit: random and directed segments
// against an in-bench fixed point predictor. Depends on lpi_pkg and the unit.
`timescale 1ns / 100ps

module line_plane_intersection_unit_tb;
  import lpi_pkg::*;

  localparam int LATENCY = 44;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct {
    logic signed [CW-1:0] hx, hy, hz;
    logic                 par, ovf;
  } hit_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [CW-1:0] in_start_x = '0, in_start_y = '0, in_start_z = '0;
  logic signed [CW-1:0] in_end_x = '0, in_end_y = '0, in_end_z = '0;
  logic out_valid;
  logic signed [CW-1:0] out_hit_x, out_hit_y, out_hit_z;
  logic out_parallel_flag, out_overflow_flag;
  logic cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CW-1:0] cfg_wdata = '0;

  logic signed [CW-1:0] plane_p [3];
  logic signed [CW-1:0] plane_n [3];
  hit_t expected_hits [$];
  int   send_idle_pct = 0;
  int   errors = 0;
  int   quiet_cycles = 0;

  line_plane_intersection_unit u_top (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Saturate a wide value to the coordinate range.
  function automatic logic signed [CW-1:0] clamp_coord(input logic signed [255:0] v,
                                                       inout logic ovf);
    logic signed [255:0] hi, lo;
    hi = (256'sd1 <<< (CW - 1)) - 1;
    lo = -(256'sd1 <<< (CW - 1));
    if (v > hi) begin
      ovf = 1'b1;
      return hi[CW-1:0];
    end
    if (v < lo) begin
      ovf = 1'b1;
      return lo[CW-1:0];
    end
    return v[CW-1:0];
  endfunction

  function automatic hit_t predict_hit(input logic signed [CW-1:0] a [3],
                                       input logic signed [CW-1:0] b [3]);
    logic signed [255:0] num, den, t, q, h;
    logic signed [255:0] na, da;
    logic signed [CW-1:0] r [3];
    logic ovf;
    hit_t res;
    num = 0;
    den = 0;
    ovf = 1'b0;
    for (int i = 0; i < 3; i++) begin
      num += 256'(plane_n[i]) * (256'(plane_p[i]) - 256'(a[i]));
      den += 256'(plane_n[i]) * (256'(b[i]) - 256'(a[i]));
    end
    if (den == 0) begin
      res.hx = a[0]; res.hy = a[1]; res.hz = a[2];
      res.par = 1'b1; res.ovf = 1'b0;
      return res;
    end
    na = num <<< FB;
    na = (na < 0) ? -na : na;
    da = (den < 0) ? -den : den;
    q = na / da;
    t = ((num < 0) != (den < 0)) ? -q : q;
    t = 256'(clamp_coord(t, ovf));
    for (int i = 0; i < 3; i++) begin
      h = 256'(a[i]) + (((256'(b[i]) - 256'(a[i])) * t) >>> FB);
      r[i] = clamp_coord(h, ovf);
    end
    res.hx = r[0]; res.hy = r[1]; res.hz = r[2];
    res.par = 1'b0; res.ovf = ovf;
    return res;
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [CW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx <= CFG_PZ) plane_p[idx] = val;
    else plane_n[idx - CFG_NX] = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_hits.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic set_plane(input logic [CW-1:0] px, py, pz, nx, ny, nz);
    wait_drained();
    write_reg(CFG_PX, px); write_reg(CFG_PY, py); write_reg(CFG_PZ, pz);
    write_reg(CFG_NX, nx); write_reg(CFG_NY, ny); write_reg(CFG_NZ, nz);
  endtask

  // Drive one segment, called at a falling edge; start is left high so the
  // next item can follow at once, and wait_drained drops it.
  task automatic send_segment(input logic signed [CW-1:0] a [3],
                              input logic signed [CW-1:0] b [3]);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_start_x <= a[0]; in_start_y <= a[1]; in_start_z <= a[2];
    in_end_x <= b[0]; in_end_y <= b[1]; in_end_z <= b[2];
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_hits.push_back(predict_hit(a, b));
    @(negedge clk);
  endtask

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $urandom_range(1, 0) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(2000000)) - 1000000) <<< $urandom_range(6);
    endcase
  endfunction

  task automatic send_random();
    logic signed [CW-1:0] a [3], b [3];
    for (int i = 0; i < 3; i++) begin
      a[i] = rand_coord();
      b[i] = ($urandom_range(9) == 0) ? a[i] : rand_coord();
    end
    send_segment(a, b);
  endtask

  task automatic test_directed();
    logic signed [CW-1:0] a [3], b [3];
    // reset plane: z = 0, normal +z
    a = '{32'sh10000, 32'sh20000, -32'sh30000};
    b = '{32'sh10000, 32'sh20000, 32'sh30000};
    send_segment(a, b);
    // parallel segment
    b = '{32'sh50000, -32'sh20000, -32'sh30000};
    send_segment(a, b);
    // extremes
    a = '{32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000};
    b = '{32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff};
    send_segment(a, b);
    send_segment(b, a);
    // degenerate: start equals end
    send_segment(a, a);
    // tiny den, large num: t saturates
    a = '{32'sh0, 32'sh0, 32'sh7000_0000};
    b = '{32'h7fff_ffff, 32'h8000_0000, 32'sh7000_0001};
    send_segment(a, b);
    b = '{32'h7fff_ffff, 32'h8000_0000, 32'sh6fff_ffff};
    send_segment(a, b);
    set_plane(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
              32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    for (int i = 0; i < 8; i++) send_random();
    set_plane(0, 0, 0, 0, 0, 0);  // all-zero normal: always parallel
    for (int i = 0; i < 4; i++) send_random();
  endtask

  task automatic test_random(input int count, input int idle_pct);
    send_idle_pct = idle_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0)
        set_plane(rand_coord(), rand_coord(), rand_coord(),
                  ($urandom_range(3) == 0) ? 32'(0) : rand_coord(),
                  ($urandom_range(3) == 0) ? 32'(0) : rand_coord(), rand_coord());
      send_random();
    end
  endtask

  // Results cannot be held off: compare each strobe against the oldest item.
  always @(posedge clk) begin
    hit_t exp_hit;
    if (rst_n && out_valid) begin
      if (expected_hits.size() == 0) begin
        $display("%0t unexpected result x=%h y=%h z=%h", $time,
                 out_hit_x, out_hit_y, out_hit_z);
        errors++;
      end else begin
        exp_hit = expected_hits.pop_front();
        if (out_hit_x !== exp_hit.hx || out_hit_y !== exp_hit.hy ||
            out_hit_z !== exp_hit.hz || out_parallel_flag !== exp_hit.par ||
            out_overflow_flag !== exp_hit.ovf) begin
          $display("%0t mismatch exp %h %h %h par=%b ovf=%b got %h %h %h par=%b ovf=%b",
                   $time, exp_hit.hx, exp_hit.hy, exp_hit.hz, exp_hit.par, exp_hit.ovf,
                   out_hit_x, out_hit_y, out_hit_z, out_parallel_flag, out_overflow_flag);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    plane_p = '{0, 0, 0};
    plane_n = '{0, 0, 32'sh10000};
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(400, 19);
    test_random(350, 62);
    test_random(350, 0);
    wait_drained();
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
